FILE: rtl/stencil_advection_3d_unit_macros.svh
// Assertion helpers for the advection stencil unit
`ifndef STENCIL_ADVECTION_3D_UNIT_MACROS_SVH
`define STENCIL_ADVECTION_3D_UNIT_MACROS_SVH

// same-cycle implication
`define SA3D_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sa3d same-cycle check failed");

// next-cycle implication
`define SA3D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sa3d next-cycle check failed");

`endif

FILE: rtl/sa3d_pkg.sv
`default_nettype none
package sa3d_pkg;

  localparam int FIELD_W = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_AW-1:0] CFG_GRID_NX = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_GRID_NY = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_GRID_NZ = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_INV_DX  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_INV_DY  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_INV_DZ  = 3'd5;

  // neighbor read order
  localparam logic [2:0] NB_E     = 3'd0;
  localparam logic [2:0] NB_W     = 3'd1;
  localparam logic [2:0] NB_N     = 3'd2;
  localparam logic [2:0] NB_S     = 3'd3;
  localparam logic [2:0] NB_B     = 3'd4;
  localparam logic [2:0] NB_COUNT = 3'd5;

  localparam logic [1:0] TERM_X = 2'd0;
  localparam logic [1:0] TERM_Y = 2'd1;
  localparam logic [1:0] TERM_Z = 2'd2;

  localparam logic [1:0] PH_MAG = 2'd0;
  localparam logic [1:0] PH_LO  = 2'd1;
  localparam logic [1:0] PH_HI  = 2'd2;
  localparam logic [1:0] PH_ACC = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       addr_calc;
    logic       rd_en;
    logic [2:0] rd_idx;
    logic       cap_en;
    logic [2:0] cap_idx;
    logic       mem_wr;
    logic       mul_en;
    logic [1:0] mul_term;
    logic [1:0] mul_phase;
    logic       out_load;
    logic       rc_setup;
    logic       rc_iter;
    logic       rc_last;
  } sa3d_cmd_t;

  typedef struct packed {
    logic emit;
    logic inner;
    logic irregular;
  } sa3d_stat_t;

endpackage
`default_nettype wire

FILE: rtl/sa3d_chan_if.sv
`default_nettype none
interface sa3d_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sa3d_pkg::FIELD_W-1:0] field_value;
  logic signed [sa3d_pkg::FIELD_W-1:0] vel_x;
  logic signed [sa3d_pkg::FIELD_W-1:0] vel_y;
  logic signed [sa3d_pkg::FIELD_W-1:0] vel_z;

  modport source (output valid, field_value, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, field_value, vel_x, vel_y, vel_z, output ready);
endinterface

interface sa3d_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sa3d_pkg::FIELD_W-1:0] adv_value;
  logic                                 grid_done;
  logic                                 saturated;

  modport source (output valid, adv_value, grid_done, saturated, input ready);
  modport sink (input valid, adv_value, grid_done, saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/stencil_advection_3d_unit.sv
// One cell is in flight at a time; the rate is set by five reads of the single-port
// field window and one shared 32x32 multiplier (three terms, four steps each), and is
// lowest for interior centres, higher for face centres and highest for first-plane cells.
// Any config write triggers a window index recompute over the MAX_NZ and plane index bits.
// Reset (sync, active low): controller idle, position zero, registers to defaults.
`default_nettype none
`include "stencil_advection_3d_unit_macros.svh"
module stencil_advection_3d_unit #(
  parameter int MAX_NX = 64,
  parameter int MAX_NY = 64,
  parameter int MAX_NZ = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  sa3d_in_if.sink                      in_chan,
  sa3d_out_if.source                   out_chan,
  input  wire                          cfg_we,
  input  wire [sa3d_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire [sa3d_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int DIV_STEPS = $clog2(MAX_NZ) + $clog2(MAX_NX * MAX_NY);

  sa3d_pkg::sa3d_cmd_t  cmd;
  sa3d_pkg::sa3d_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  sa3d_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  sa3d_dp #(
    .MAX_NX (MAX_NX),
    .MAX_NY (MAX_NY),
    .MAX_NZ (MAX_NZ)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_field_value (in_chan.field_value),
    .in_vel_x       (in_chan.vel_x),
    .in_vel_y       (in_chan.vel_y),
    .in_vel_z       (in_chan.vel_z),
    .cmd            (cmd),
    .stat           (stat),
    .out_adv_value  (out_chan.adv_value),
    .out_grid_done  (out_chan.grid_done),
    .out_saturated  (out_chan.saturated)
  );

  // one cell in flight at a time
  `SA3D_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_chan.valid && in_chan.ready, !in_ready)
  // a register write always blocks input until the index recompute is done
  `SA3D_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_we, !in_ready)
  // a clamped result sits at one of the two range limits
  `SA3D_ASSERT_NOW(a_sat_limits, clk, rst_n, out_valid && out_chan.saturated, (out_chan.adv_value == 32'sh7FFF_FFFF) || (out_chan.adv_value == 32'sh8000_0000))

endmodule
`default_nettype wire

FILE: rtl/sa3d_ctrl.sv
`default_nettype none
module sa3d_ctrl #(
  parameter int DIV_STEPS = 22
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire                    out_ready,
  input  wire                    cfg_we,
  input  sa3d_pkg::sa3d_stat_t   stat,
  output sa3d_pkg::sa3d_cmd_t    cmd
);

  localparam int DIV_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_FETCH, S_MUL, S_OUT, S_RC_WAIT, S_RC_SETUP, S_RC_DIV
  } state_t;

  state_t           state_r;
  logic [2:0]       step_r;
  logic [1:0]       term_r;
  logic [1:0]       phase_r;
  logic [DIV_W-1:0] div_cnt_r;
  logic             rc_pend_r;
  logic             out_valid_r;
  logic             accept;
  logic             rc_busy;

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE) && !rc_pend_r;
  assign accept    = in_valid && in_ready;
  assign rc_busy   = (state_r == S_RC_WAIT) || (state_r == S_RC_SETUP) ||
                     (state_r == S_RC_DIV);

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = accept;
      end
      S_ADDR: begin
        cmd.addr_calc = 1'b1;
      end
      S_FETCH: begin
        cmd.rd_en   = step_r < sa3d_pkg::NB_COUNT;
        cmd.rd_idx  = step_r;
        cmd.cap_en  = step_r != sa3d_pkg::NB_E;
        cmd.cap_idx = step_r - 3'd1;
        cmd.mem_wr  = step_r == sa3d_pkg::NB_COUNT;
      end
      S_MUL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_term  = term_r;
        cmd.mul_phase = phase_r;
      end
      S_OUT: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      S_RC_SETUP: begin
        cmd.rc_setup = 1'b1;
      end
      S_RC_DIV: begin
        cmd.rc_iter = 1'b1;
        cmd.rc_last = div_cnt_r == DIV_W'(DIV_STEPS - 1);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      term_r      <= '0;
      phase_r     <= '0;
      div_cnt_r   <= '0;
      rc_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (rc_pend_r) begin
            state_r   <= S_RC_WAIT;
            rc_pend_r <= 1'b0;
          end else if (accept) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_r <= S_FETCH;
          step_r  <= '0;
        end
        S_FETCH: begin
          if (step_r == sa3d_pkg::NB_COUNT) begin
            if (stat.irregular) begin
              rc_pend_r <= 1'b1;
            end
            if (!stat.emit) begin
              state_r <= S_IDLE;
            end else if (stat.inner) begin
              state_r <= S_MUL;
              term_r  <= sa3d_pkg::TERM_X;
              phase_r <= sa3d_pkg::PH_MAG;
            end else begin
              state_r <= S_OUT;
            end
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_MUL: begin
          if (phase_r == sa3d_pkg::PH_ACC) begin
            phase_r <= sa3d_pkg::PH_MAG;
            if (term_r == sa3d_pkg::TERM_Z) begin
              state_r <= S_OUT;
            end else begin
              term_r <= term_r + 2'd1;
            end
          end else begin
            phase_r <= phase_r + 2'd1;
          end
        end
        S_OUT: begin
          if (cmd.out_load) begin
            state_r <= S_IDLE;
          end
        end
        S_RC_WAIT: begin
          state_r <= S_RC_SETUP;
        end
        S_RC_SETUP: begin
          state_r   <= S_RC_DIV;
          div_cnt_r <= '0;
        end
        S_RC_DIV: begin
          if (cmd.rc_last) begin
            state_r <= S_IDLE;
          end else begin
            div_cnt_r <= div_cnt_r + DIV_W'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // a register write restarts the window index recompute, or queues it when none is running
      if (cfg_we) begin
        if (rc_busy) begin
          state_r <= S_RC_WAIT;
        end else begin
          rc_pend_r <= 1'b1;
        end
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sa3d_dp.sv
`default_nettype none
module sa3d_dp #(
  parameter int MAX_NX = 64,
  parameter int MAX_NY = 64,
  parameter int MAX_NZ = 1024
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [sa3d_pkg::CFG_AW-1:0]          cfg_addr,
  input  wire  [sa3d_pkg::CFG_DW-1:0]          cfg_wdata,
  input  wire  signed [sa3d_pkg::FIELD_W-1:0]  in_field_value,
  input  wire  signed [sa3d_pkg::FIELD_W-1:0]  in_vel_x,
  input  wire  signed [sa3d_pkg::FIELD_W-1:0]  in_vel_y,
  input  wire  signed [sa3d_pkg::FIELD_W-1:0]  in_vel_z,
  input  sa3d_pkg::sa3d_cmd_t                   cmd,
  output sa3d_pkg::sa3d_stat_t                  stat,
  output logic signed [sa3d_pkg::FIELD_W-1:0] out_adv_value,
  output logic                                  out_grid_done,
  output logic                                  out_saturated
);

  localparam int XW  = $clog2(MAX_NX);
  localparam int YW  = $clog2(MAX_NY);
  localparam int ZW  = $clog2(MAX_NZ);
  localparam int NXW = $clog2(MAX_NX + 1);
  localparam int NYW = $clog2(MAX_NY + 1);
  localparam int NZW = $clog2(MAX_NZ + 1);
  localparam int PD  = MAX_NX * MAX_NY;
  localparam int PW  = $clog2(PD);
  localparam int PLW = $clog2(PD + 1);
  localparam int WD  = 2 * PD + 1;
  localparam int LW  = $clog2(WD);
  localparam int WW  = $clog2(WD + 1);
  localparam int DW  = ZW + PW;
  localparam int AW  = 99;

  // configuration
  logic [6:0]  gnx_r, gny_r;
  logic [10:0] gnz_r;
  logic [31:0] rx_r, ry_r, rz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gnx_r <= 7'd64;
      gny_r <= 7'd64;
      gnz_r <= 11'd64;
      rx_r  <= 32'd32768;
      ry_r  <= 32'd32768;
      rz_r  <= 32'd32768;
    end else if (cfg_we) begin
      case (cfg_addr)
        sa3d_pkg::CFG_GRID_NX: gnx_r <= cfg_wdata[6:0];
        sa3d_pkg::CFG_GRID_NY: gny_r <= cfg_wdata[6:0];
        sa3d_pkg::CFG_GRID_NZ: gnz_r <= cfg_wdata[10:0];
        sa3d_pkg::CFG_INV_DX:  rx_r  <= cfg_wdata;
        sa3d_pkg::CFG_INV_DY:  ry_r  <= cfg_wdata;
        sa3d_pkg::CFG_INV_DZ:  rz_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // clamped sizes, plane size and window length
  logic [31:0]    nx_c, ny_c, nz_c;
  logic [PLW-1:0] p_c;
  logic [NXW-1:0] nx_r;
  logic [NYW-1:0] ny_r;
  logic [NZW-1:0] nz_r;
  logic [PLW-1:0] p_r;
  logic [WW-1:0]  w_r;

  always_comb begin
    nx_c = 32'(gnx_r);
    ny_c = 32'(gny_r);
    nz_c = 32'(gnz_r);
    if (nx_c < 32'd3) begin
      nx_c = 32'd3;
    end else if (nx_c > 32'(MAX_NX)) begin
      nx_c = 32'(MAX_NX);
    end
    if (ny_c < 32'd3) begin
      ny_c = 32'd3;
    end else if (ny_c > 32'(MAX_NY)) begin
      ny_c = 32'(MAX_NY);
    end
    if (nz_c < 32'd3) begin
      nz_c = 32'd3;
    end else if (nz_c > 32'(MAX_NZ)) begin
      nz_c = 32'(MAX_NZ);
    end
    p_c = PLW'(nx_c[NXW-1:0]) * PLW'(ny_c[NYW-1:0]);
  end

  always_ff @(posedge clk) begin
    nx_r <= nx_c[NXW-1:0];
    ny_r <= ny_c[NYW-1:0];
    nz_r <= nz_c[NZW-1:0];
    p_r  <= p_c;
    w_r  <= {p_c, 1'b0} + WW'(1);
  end

  // position of the next cell and its window slot
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [ZW-1:0] z_r, z_nxt;
  logic [LW-1:0] lin_r, lin_adv;
  logic [31:0]   xe, ye, ze, nxe, nye, nze, l1;
  logic          irregular;
  logic [PW-1:0] vi_c;

  always_comb begin
    xe  = 32'(x_r);
    ye  = 32'(y_r);
    ze  = 32'(z_r);
    nxe = 32'(nx_r);
    nye = 32'(ny_r);
    nze = 32'(nz_r);
    l1  = 32'(lin_r) + 32'd1;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    irregular = 1'b0;
    lin_adv   = (l1 == 32'(w_r)) ? '0 : l1[LW-1:0];
    if (xe + 32'd1 < nxe) begin
      x_nxt = x_r + XW'(1);
    end else begin
      x_nxt = '0;
      if (ye + 32'd1 < nye) begin
        y_nxt     = y_r + YW'(1);
        irregular = xe != nxe - 32'd1;
      end else begin
        y_nxt = '0;
        if (ze + 32'd1 < nze) begin
          z_nxt     = z_r + ZW'(1);
          irregular = (xe != nxe - 32'd1) || (ye != nye - 32'd1);
        end else begin
          z_nxt   = '0;
          lin_adv = '0;
        end
      end
    end
    vi_c = PW'(y_r) * PW'(nx_r) + PW'(x_r);
  end

  // window index recompute: restoring remainder, one bit per cycle
  logic [DW-1:0] dv_r;
  logic [LW-1:0] rem_r;
  logic [LW:0]   rem_t, rem_w, rem_nxt;

  always_comb begin
    rem_t   = {rem_r, dv_r[DW-1]};
    rem_w   = (LW+1)'(w_r);
    rem_nxt = (rem_t >= rem_w) ? rem_t - rem_w : rem_t;
  end

  always_ff @(posedge clk) begin
    if (cmd.rc_setup) begin
      dv_r  <= DW'(z_r) * DW'(p_r) + DW'(vi_c);
      rem_r <= '0;
    end else if (cmd.rc_iter) begin
      dv_r  <= dv_r << 1;
      rem_r <= rem_nxt[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      z_r   <= '0;
      lin_r <= '0;
    end else if (cmd.mem_wr) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      lin_r <= lin_adv;
    end else if (cmd.rc_iter && cmd.rc_last) begin
      lin_r <= rem_nxt[LW-1:0];
    end
  end

  // item registers and per-item flags
  logic signed [31:0] fin_r, vinx_r, viny_r, vinz_r;
  logic [PW-1:0]      vi_r;
  logic               inner_r, done_r, emit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fin_r  <= in_field_value;
      vinx_r <= in_vel_x;
      viny_r <= in_vel_y;
      vinz_r <= in_vel_z;
    end
    if (cmd.addr_calc) begin
      vi_r    <= vi_c;
      emit_r  <= ze != 32'd0;
      done_r  <= (xe + 32'd1 >= nxe) && (ye + 32'd1 >= nye) && (ze + 32'd1 >= nze);
      inner_r <= (xe >= 32'd1) && (xe + 32'd2 <= nxe) && (ye >= 32'd1) &&
                 (ye + 32'd2 <= nye) && (ze >= 32'd2) && (ze + 32'd1 <= nze);
    end
  end

  assign stat.emit      = emit_r;
  assign stat.inner     = inner_r;
  assign stat.irregular = irregular;

  // neighbor slot: (lin - k) modulo window length
  logic [WW-1:0] nb_k;
  logic [WW:0]   nb_sum, nb_mod;
  logic [LW-1:0] rd_addr;

  always_comb begin
    case (cmd.rd_idx)
      sa3d_pkg::NB_E: nb_k = WW'(p_r) - WW'(1);
      sa3d_pkg::NB_W: nb_k = WW'(p_r) + WW'(1);
      sa3d_pkg::NB_N: nb_k = WW'(p_r) - WW'(nx_r);
      sa3d_pkg::NB_S: nb_k = WW'(p_r) + WW'(nx_r);
      sa3d_pkg::NB_B: nb_k = {p_r, 1'b0};
      default:        nb_k = '0;
    endcase
    nb_sum  = (WW+1)'(lin_r) + {1'b0, w_r} - {1'b0, nb_k};
    nb_mod  = (nb_sum >= {1'b0, w_r}) ? nb_sum - {1'b0, w_r} : nb_sum;
    rd_addr = nb_mod[LW-1:0];
  end

  // stores
  logic [31:0] fwin_mem [WD];
  logic [31:0] velx_mem [PD];
  logic [31:0] vely_mem [PD];
  logic [31:0] velz_mem [PD];
  logic signed [31:0] fq_r, vqx_r, vqy_r, vqz_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      fq_r <= fwin_mem[rd_addr];
    end
    if (cmd.mem_wr) begin
      fwin_mem[lin_r] <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en && cmd.rd_idx == sa3d_pkg::NB_E) begin
      vqx_r <= velx_mem[vi_r];
      vqy_r <= vely_mem[vi_r];
      vqz_r <= velz_mem[vi_r];
    end
    if (cmd.mem_wr) begin
      velx_mem[vi_r] <= vinx_r;
      vely_mem[vi_r] <= viny_r;
      velz_mem[vi_r] <= vinz_r;
    end
  end

  logic signed [31:0] fe_r, fw_r, fn_r, fs_r, fb_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_idx)
        sa3d_pkg::NB_E: fe_r <= fq_r;
        sa3d_pkg::NB_W: fw_r <= fq_r;
        sa3d_pkg::NB_N: fn_r <= fq_r;
        sa3d_pkg::NB_S: fs_r <= fq_r;
        sa3d_pkg::NB_B: fb_r <= fq_r;
        default: begin
        end
      endcase
    end
  end

  // term arithmetic on one shared 32x32 multiplier, sign-magnitude
  logic signed [31:0] vel_s;
  logic signed [32:0] diff_s, diff_neg;
  logic [31:0]        r_s, mv, md, vel_neg, mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        m_r, pl_r;
  logic [62:0]        ph_r;
  logic               neg_r;
  logic [94:0]        prod;
  logic [AW-1:0]      acc_r;

  always_comb begin
    case (cmd.mul_term)
      sa3d_pkg::TERM_X: begin
        vel_s  = vqx_r;
        diff_s = 33'(fe_r) - 33'(fw_r);
        r_s    = rx_r;
      end
      sa3d_pkg::TERM_Y: begin
        vel_s  = vqy_r;
        diff_s = 33'(fn_r) - 33'(fs_r);
        r_s    = ry_r;
      end
      default: begin
        vel_s  = vqz_r;
        diff_s = 33'(fin_r) - 33'(fb_r);
        r_s    = rz_r;
      end
    endcase
    vel_neg  = ~vel_s + 32'd1;
    diff_neg = ~diff_s + 33'd1;
    mv = vel_s[31] ? vel_neg : vel_s;
    md = diff_s[32] ? diff_neg[31:0] : diff_s[31:0];
    case (cmd.mul_phase)
      sa3d_pkg::PH_MAG: begin
        mul_a = mv;
        mul_b = md;
      end
      sa3d_pkg::PH_LO: begin
        mul_a = m_r[31:0];
        mul_b = r_s;
      end
      default: begin
        mul_a = {1'b0, m_r[62:32]};
        mul_b = r_s;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
    prod  = {ph_r, 32'b0} + 95'(pl_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_calc) begin
      acc_r <= '0;
    end else if (cmd.mul_en) begin
      case (cmd.mul_phase)
        sa3d_pkg::PH_MAG: begin
          m_r   <= mul_p;
          neg_r <= vel_s[31] ^ diff_s[32];
        end
        sa3d_pkg::PH_LO: pl_r <= mul_p;
        sa3d_pkg::PH_HI: ph_r <= mul_p[62:0];
        sa3d_pkg::PH_ACC: acc_r <= neg_r ? acc_r - AW'(prod) : acc_r + AW'(prod);
        default: begin
        end
      endcase
    end
  end

  // floor shift by 32, then saturate; cells that are not interior give zero
  logic fits;
  assign fits = (&acc_r[AW-1:63]) || !(|acc_r[AW-1:63]);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_grid_done <= done_r;
      if (!inner_r) begin
        out_adv_value <= '0;
        out_saturated <= 1'b0;
      end else if (fits) begin
        out_adv_value <= acc_r[63:32];
        out_saturated <= 1'b0;
      end else begin
        out_adv_value <= acc_r[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        out_saturated <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
